// ===== src/tia_pkg.sv =====
// Shared types, opcodes and width helpers for the typed integer ALU.
// No dependencies.
`default_nettype none
package tia_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned ModeW    = 6;
  localparam int unsigned WcW      = 2;
  localparam int unsigned FieldW   = 5;   // counts, offsets and shifts use 5 bits
  localparam int unsigned DivSteps = DataW;

  typedef enum logic [ModeW-1:0] {
    OpAnd    = 6'd0,  OpOr     = 6'd1,  OpXor   = 6'd2,  OpNot   = 6'd3,
    OpIns    = 6'd4,  OpUExt   = 6'd5,  OpSExt  = 6'd6,  OpShl   = 6'd7,
    OpAshr   = 6'd8,  OpLshr   = 6'd9,  OpAdd   = 6'd10, OpSub   = 6'd11,
    OpAbs    = 6'd12, OpNeg    = 6'd13, OpMul   = 6'd14, OpUdiv  = 6'd15,
    OpUmod   = 6'd16, OpSmin   = 6'd17, OpSmax  = 6'd18, OpSclamp = 6'd19,
    OpUmin   = 6'd20, OpUmax   = 6'd21, OpUclamp = 6'd22, OpEq   = 6'd23,
    OpNe     = 6'd24, OpSlt    = 6'd25, OpSle   = 6'd26, OpSgt   = 6'd27,
    OpSge    = 6'd28, OpUlt    = 6'd29, OpUle   = 6'd30, OpUgt   = 6'd31,
    OpUge    = 6'd32, OpBand   = 6'd33, OpBor   = 6'd34, OpBeq   = 6'd35,
    OpBne    = 6'd36, OpBnot   = 6'd37
  } op_e;

  typedef enum logic [WcW-1:0] {
    W8 = 2'd0, W16 = 2'd1, W32 = 2'd2, W64 = 2'd3
  } wc_e;

  // opcode and width as carried through the front stages
  typedef struct packed {
    op_e op;
    wc_e wc;
  } ctl_t;

  // what the divider stages need to pick the final result
  typedef struct packed {
    logic is_div;
    logic is_mod;
    wc_e  wc;
  } div_ctl_t;

  function automatic logic [DataW-1:0] wmask(wc_e wc);
    logic [DataW-1:0] m;
    unique case (wc)
      W8:      m = {{(DataW-8){1'b0}}, {8{1'b1}}};
      W16:     m = {{(DataW-16){1'b0}}, {16{1'b1}}};
      W32:     m = {{(DataW-32){1'b0}}, {32{1'b1}}};
      default: m = {DataW{1'b1}};
    endcase
    return m;
  endfunction

  function automatic logic [DataW-1:0] sext(logic [DataW-1:0] x, wc_e wc);
    logic [DataW-1:0] s;
    unique case (wc)
      W8:      s = {{(DataW-8){x[7]}}, x[7:0]};
      W16:     s = {{(DataW-16){x[15]}}, x[15:0]};
      W32:     s = {{(DataW-32){x[31]}}, x[31:0]};
      default: s = x;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== src/tia_prep.sv =====
// Input stage: registers operands masked and sign-extended to the width.
// Depends on tia_pkg.
`default_nettype none
module tia_prep (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [5:0]               mode_i,
  input  logic [1:0]               width_code_i,
  input  logic [63:0]              a_i,
  input  logic [63:0]              b_i,
  input  logic [63:0]              c_i,
  input  logic [63:0]              d_i,
  output logic                     valid_o,
  output tia_pkg::ctl_t            ctl_o,
  output logic [63:0]              ua_o,
  output logic [63:0]              ub_o,
  output logic [63:0]              uc_o,
  output logic [63:0]              ud_o,
  output logic [63:0]              sa_o,
  output logic [63:0]              sb_o,
  output logic [63:0]              sc_o
);
  import tia_pkg::*;

  logic             v_q;
  ctl_t             ctl_q;
  logic [DataW-1:0] ua_q, ub_q, uc_q, ud_q, sa_q, sb_q, sc_q;
  wc_e              wc;
  logic [DataW-1:0] m;

  assign wc = wc_e'(width_code_i);
  assign m  = wmask(wc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q.op <= op_e'(mode_i);
      ctl_q.wc <= wc;
      ua_q     <= a_i & m;
      ub_q     <= b_i & m;
      uc_q     <= c_i & m;
      ud_q     <= d_i & m;
      sa_q     <= sext(a_i, wc);
      sb_q     <= sext(b_i, wc);
      sc_q     <= sext(c_i, wc);
    end
  end

  assign valid_o = v_q;
  assign ctl_o   = ctl_q;
  assign ua_o    = ua_q;
  assign ub_o    = ub_q;
  assign uc_o    = uc_q;
  assign ud_o    = ud_q;
  assign sa_o    = sa_q;
  assign sb_o    = sb_q;
  assign sc_o    = sc_q;

endmodule
`default_nettype wire

// ===== src/tia_exec.sv =====
// Two execute stages: bit/logic/add/compare ops plus split 64-bit multiply.
// Depends on tia_pkg.
`default_nettype none
module tia_exec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tia_pkg::ctl_t       ctl_i,
  input  logic [63:0]         ua_i,
  input  logic [63:0]         ub_i,
  input  logic [63:0]         uc_i,
  input  logic [63:0]         ud_i,
  input  logic [63:0]         sa_i,
  input  logic [63:0]         sb_i,
  input  logic [63:0]         sc_i,
  output logic                valid_o,
  output tia_pkg::div_ctl_t   dctl_o,
  output logic [63:0]         r_o,
  output logic [63:0]         ua_o,
  output logic [63:0]         ub_o
);
  import tia_pkg::*;

  // stage 2
  logic [DataW-1:0] r2_d;
  logic [FieldW-1:0] sh, ofs_i, cnt_i, ofs_x, cnt_x;
  logic [DataW-1:0] lo_i, msk_i, lo_x, ext_v;
  logic s_ab, s_ba, s_ca, u_ab, u_ba, u_ca, za, zb;
  logic [31:0] al, ah, bl, bh;

  logic             v2_q;
  div_ctl_t         dctl2_q;
  logic             mul2_q;
  logic [DataW-1:0] r2_q, ua2_q, ub2_q, p0_q;
  logic [31:0]      p1_q, p2_q;

  // stage 3
  logic             v3_q;
  div_ctl_t         dctl3_q;
  logic [DataW-1:0] r3_q, ua3_q, ub3_q;
  logic [DataW-1:0] mul;

  assign sh    = ub_i[FieldW-1:0];
  assign ofs_i = uc_i[FieldW-1:0];
  assign cnt_i = ud_i[FieldW-1:0];
  assign ofs_x = ub_i[FieldW-1:0];
  assign cnt_x = uc_i[FieldW-1:0];
  assign lo_i  = (64'd1 << cnt_i) - 64'd1;
  assign msk_i = lo_i << ofs_i;
  assign lo_x  = (64'd1 << cnt_x) - 64'd1;

  always_comb begin
    ext_v = (ua_i >> ofs_x) & lo_x;
    if (ctl_i.op == OpSExt && cnt_x != '0 && ext_v[cnt_x - 5'd1]) begin
      ext_v = ext_v | ~lo_x;
    end
  end

  assign s_ab = $signed(sa_i) < $signed(sb_i);
  assign s_ba = $signed(sb_i) < $signed(sa_i);
  assign s_ca = $signed(sc_i) < $signed(sa_i);
  assign u_ab = ua_i < ub_i;
  assign u_ba = ub_i < ua_i;
  assign u_ca = uc_i < ua_i;
  assign za   = ua_i == '0;
  assign zb   = ub_i == '0;

  always_comb begin
    r2_d = '0;
    unique case (ctl_i.op)
      OpAnd:    r2_d = ua_i & ub_i;
      OpOr:     r2_d = ua_i | ub_i;
      OpXor:    r2_d = ua_i ^ ub_i;
      OpNot:    r2_d = ~ua_i;
      OpIns:    r2_d = (ua_i & ~msk_i) | ((ub_i << ofs_i) & msk_i);
      OpUExt,
      OpSExt:   r2_d = ext_v;
      OpShl:    r2_d = ua_i << sh;
      OpAshr:   r2_d = $unsigned($signed(sa_i) >>> sh);
      OpLshr:   r2_d = ua_i >> sh;
      OpAdd:    r2_d = sa_i + sb_i;
      OpSub:    r2_d = sa_i - sb_i;
      OpAbs:    r2_d = sa_i[DataW-1] ? (64'd0 - sa_i) : sa_i;
      OpNeg:    r2_d = 64'd0 - sa_i;
      OpSmin:   r2_d = s_ba ? sb_i : sa_i;
      OpSmax:   r2_d = s_ab ? sb_i : sa_i;
      OpSclamp: r2_d = s_ab ? sb_i : (s_ca ? sc_i : sa_i);
      OpUmin:   r2_d = u_ba ? ub_i : ua_i;
      OpUmax:   r2_d = u_ab ? ub_i : ua_i;
      OpUclamp: r2_d = u_ab ? ub_i : (u_ca ? uc_i : ua_i);
      OpEq:     r2_d = {63'd0, ua_i == ub_i};
      OpNe:     r2_d = {63'd0, ua_i != ub_i};
      OpSlt:    r2_d = {63'd0, s_ab};
      OpSle:    r2_d = {63'd0, !s_ba};
      OpSgt:    r2_d = {63'd0, s_ba};
      OpSge:    r2_d = {63'd0, !s_ab};
      OpUlt:    r2_d = {63'd0, u_ab};
      OpUle:    r2_d = {63'd0, !u_ba};
      OpUgt:    r2_d = {63'd0, u_ba};
      OpUge:    r2_d = {63'd0, !u_ab};
      OpBand:   r2_d = {63'd0, !za && !zb};
      OpBor:    r2_d = {63'd0, !za || !zb};
      OpBeq:    r2_d = {63'd0, za == zb};
      OpBne:    r2_d = {63'd0, za != zb};
      OpBnot:   r2_d = {63'd0, za};
      default:  r2_d = '0;  // mul/div/mod handled later, unused codes give 0
    endcase
  end

  // low 64 bits of a*b from three 32x32 products
  assign al = sa_i[31:0];
  assign ah = sa_i[63:32];
  assign bl = sb_i[31:0];
  assign bh = sb_i[63:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dctl2_q.is_div <= ctl_i.op == OpUdiv;
      dctl2_q.is_mod <= ctl_i.op == OpUmod;
      dctl2_q.wc     <= ctl_i.wc;
      mul2_q         <= ctl_i.op == OpMul;
      r2_q           <= r2_d;
      ua2_q          <= ua_i;
      ub2_q          <= ub_i;
      p0_q           <= 64'(al) * 64'(bl);
      p1_q           <= al * bh;
      p2_q           <= ah * bl;

      dctl3_q        <= dctl2_q;
      r3_q           <= mul2_q ? mul : r2_q;
      ua3_q          <= ua2_q;
      ub3_q          <= ub2_q;
    end
  end

  assign mul = p0_q + {p1_q + p2_q, 32'd0};

  assign valid_o = v3_q;
  assign dctl_o  = dctl3_q;
  assign r_o     = r3_q;
  assign ua_o    = ua3_q;
  assign ub_o    = ub3_q;

endmodule
`default_nettype wire

// ===== src/tia_div.sv =====
// Unsigned divider, one quotient bit per stage, plus the output register.
// Depends on tia_pkg.
`default_nettype none
module tia_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tia_pkg::div_ctl_t   dctl_i,
  input  logic [63:0]         r_i,
  input  logic [63:0]         ua_i,
  input  logic [63:0]         ub_i,
  output logic                valid_o,
  output logic [63:0]         result_o
);
  import tia_pkg::*;

  logic             v_q    [DivSteps];
  div_ctl_t         ctl_q  [DivSteps];
  logic [DataW-1:0] r_q    [DivSteps];
  logic [DataW-1:0] rem_q  [DivSteps];
  logic [DataW-1:0] dv_q   [DivSteps];  // dividend shifting out, quotient shifting in
  logic [DataW-1:0] dsr_q  [DivSteps];

  logic             out_v_q;
  logic [DataW-1:0] out_q;
  logic [DataW-1:0] pick;

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic             v_in;
    div_ctl_t         ctl_in;
    logic [DataW-1:0] r_in, rem_in, dv_in, dsr_in;
    logic [DataW:0]   shf;
    logic [DataW+1:0] diff;
    logic             qb;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign ctl_in = dctl_i;
      assign r_in   = r_i;
      assign rem_in = '0;
      assign dv_in  = ua_i;
      assign dsr_in = ub_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign ctl_in = ctl_q[k-1];
      assign r_in   = r_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dv_in  = dv_q[k-1];
      assign dsr_in = dsr_q[k-1];
    end

    assign shf  = {rem_in, dv_in[DataW-1]};
    assign diff = {1'b0, shf} - {2'b00, dsr_in};
    assign qb   = ~diff[DataW+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctl_q[k] <= ctl_in;
        r_q[k]   <= r_in;
        rem_q[k] <= qb ? diff[DataW-1:0] : shf[DataW-1:0];
        dv_q[k]  <= {dv_in[DataW-2:0], qb};
        dsr_q[k] <= dsr_in;
      end
    end
  end

  // zero divisor falls out naturally: quotient all ones, remainder = dividend
  always_comb begin
    priority if (ctl_q[DivSteps-1].is_div) begin
      pick = dv_q[DivSteps-1];
    end else if (ctl_q[DivSteps-1].is_mod) begin
      pick = rem_q[DivSteps-1];
    end else begin
      pick = r_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= pick & wmask(ctl_q[DivSteps-1].wc);
    end
  end

  assign valid_o  = out_v_q;
  assign result_o = out_q;

endmodule
`default_nettype wire

// ===== src/typed_integer_alu.sv =====
// Top level of the typed integer ALU: prep stage, execute stages, divider stages.
// Depends on tia_pkg, tia_prep, tia_exec, tia_div.
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+-------------------------------------------
//  request  | in_valid_i  | in_ready_o  | mode_i width_code_i operand_a/b/c/d_i
//  result   | out_valid_o | out_ready_i | result_o
//
// One request per cycle, every opcode, while the output is not stalled. Stages:
// one operand stage, two execute stages (the 64-bit multiply is split over them),
// 64 divider stages retiring one quotient bit each, and the output register.
// Every opcode goes through the divider stages so results leave in request order.
// Reset clears all valid bits; payload registers are not reset.
// A stalled result freezes the whole pipe: in_ready_o is low exactly when the
// output register holds a result the consumer has not taken.
`default_nettype none
module typed_integer_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [5:0]  mode_i,
  input  logic [1:0]  width_code_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  input  logic [63:0] operand_c_i,
  input  logic [63:0] operand_d_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_o
);
  import tia_pkg::*;

  logic en;

  // operand stage outputs
  logic             p_v;
  ctl_t             p_ctl;
  logic [DataW-1:0] p_ua, p_ub, p_uc, p_ud, p_sa, p_sb, p_sc;

  // execute stage outputs
  logic             x_v;
  div_ctl_t         x_dctl;
  logic [DataW-1:0] x_r, x_ua, x_ub;

  // global advance: the pipe moves unless the output holds an untaken result
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  tia_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .mode_i       (mode_i),
    .width_code_i (width_code_i),
    .a_i          (operand_a_i),
    .b_i          (operand_b_i),
    .c_i          (operand_c_i),
    .d_i          (operand_d_i),
    .valid_o      (p_v),
    .ctl_o        (p_ctl),
    .ua_o         (p_ua),
    .ub_o         (p_ub),
    .uc_o         (p_uc),
    .ud_o         (p_ud),
    .sa_o         (p_sa),
    .sb_o         (p_sb),
    .sc_o         (p_sc)
  );

  tia_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_v),
    .ctl_i   (p_ctl),
    .ua_i    (p_ua),
    .ub_i    (p_ub),
    .uc_i    (p_uc),
    .ud_i    (p_ud),
    .sa_i    (p_sa),
    .sb_i    (p_sb),
    .sc_i    (p_sc),
    .valid_o (x_v),
    .dctl_o  (x_dctl),
    .r_o     (x_r),
    .ua_o    (x_ua),
    .ub_o    (x_ub)
  );

  tia_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (x_v),
    .dctl_i   (x_dctl),
    .r_i      (x_r),
    .ua_i     (x_ua),
    .ub_i     (x_ub),
    .valid_o  (out_valid_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

// ===== src/tia_checker.sv =====
// Port-level checks for typed_integer_alu, bound onto the top level.
// Depends on typed_integer_alu ports only.
`default_nettype none
module tia_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] result_o
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("result changed while stalled");

  // the pipe only stops while a result waits on the consumer
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request refused with empty output");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while output stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind typed_integer_alu tia_checker u_tia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .result_o    (result_o)
);
`default_nettype wire
